FILE: sv/bblc_pkg.sv
package bblc_pkg;

    localparam int NUM_CORES  = 2;
    localparam int HEAD_SLOTS = 4096;
    localparam int MAX_PROBES = 32;
    localparam int TOP_BUCKET = 64;

    localparam int CORE_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int SLOT_W  = $clog2(HEAD_SLOTS);
    localparam int PROBE_W = $clog2(MAX_PROBES + 1);
    localparam int HIST_W  = $clog2(TOP_BUCKET + 1);

    localparam logic [31:0] HASH_MUL = 32'h2545F491;

    localparam logic [1:0] OUTCOME_NEW     = 2'd0;
    localparam logic [1:0] OUTCOME_MATCH   = 2'd1;
    localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

    localparam logic FUNC_RETIRE = 1'b0;
    localparam logic FUNC_CLOSE  = 1'b1;

    typedef logic [63:0] cnt_t;

endpackage

FILE: sv/basic_block_length_census_unit.sv
// Timing: a retire that closes no run leaves the block idle; the next request can
// follow at once. A close runs S_HASH1, S_HASH2, an S_HREAD, S_HWAIT, S_HCHK round per
// head table probe (1 to 32, and a drop round when all 32 miss), S_HIST, S_HISTW and
// S_OUT, which raises out_valid. Throughput: one request at a time; no request is taken
// while a result is held. Reset: asynchronous, active low. After reset the block sweeps
// the histogram and head table memories clear, one entry a cycle, before taking a request.
module basic_block_length_census_unit
    import bblc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic        core,
    input  logic [31:0] pc,
    input  logic [31:0] next_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] block_start,
    output logic [31:0] block_length,
    output logic [6:0]  bucket,
    output logic [63:0] bucket_blocks,
    output logic [63:0] bucket_instrs,
    output logic [63:0] total_blocks,
    output logic [63:0] total_instrs,
    output logic [63:0] total_len_squared,
    output logic [1:0]  head_outcome,
    output logic [11:0] head_slot,
    output logic [63:0] head_blocks,
    output logic [63:0] head_instrs
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH1 = 4'd2;
    localparam logic [3:0] S_HASH2 = 4'd3;
    localparam logic [3:0] S_HREAD = 4'd4;
    localparam logic [3:0] S_HWAIT = 4'd5;
    localparam logic [3:0] S_HCHK  = 4'd6;
    localparam logic [3:0] S_HIST  = 4'd7;
    localparam logic [3:0] S_HISTW = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [SLOT_W-1:0] clr_reg;

    // Per-core run state is small; kept in flip-flops.
    logic [31:0] run_expected_reg [NUM_CORES];
    logic [31:0] run_start_reg [NUM_CORES];
    logic [31:0] run_length_reg [NUM_CORES];

    // Head table and histogram memories.
    logic [31:0] head_pc_mem [HEAD_SLOTS];
    cnt_t        head_blk_mem [HEAD_SLOTS];
    cnt_t        head_ins_mem [HEAD_SLOTS];
    cnt_t        hist_blk_mem [TOP_BUCKET+1];
    cnt_t        hist_ins_mem [TOP_BUCKET+1];

    logic [31:0] hpc_rd_reg;
    cnt_t        hblk_rd_reg, hins_rd_reg, gblk_rd_reg, gins_rd_reg;

    logic [31:0] start_reg, len_reg, hash_reg;
    logic [63:0] sq_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [HIST_W-1:0] bk_reg;

    cnt_t sum_blocks_reg, sum_instrs_reg, sum_sq_reg;

    logic        head_we, hist_we, clearing;
    logic [SLOT_W-1:0] head_addr;
    logic [31:0] head_wpc;
    cnt_t        head_wblk, head_wins, hist_wblk, hist_wins;

    logic [CORE_W-1:0] in_core;
    logic [31:0] cur_len;

    assign in_core  = CORE_W'(core);
    assign cur_len  = run_length_reg[in_core];
    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        head_addr = clearing ? clr_reg : SLOT_W'(hash_reg + 32'(probe_reg));
        head_we   = clearing;
        head_wpc  = start_reg;
        head_wblk = '0;
        head_wins = '0;
        if (state_reg == S_HCHK && probe_reg < PROBE_W'(MAX_PROBES)) begin
            if (hblk_rd_reg == '0) begin
                head_we   = 1'b1;
                head_wblk = 64'd1;
                head_wins = {32'd0, len_reg};
            end else if (hpc_rd_reg == start_reg) begin
                head_we   = 1'b1;
                head_wblk = hblk_rd_reg + 64'd1;
                head_wins = hins_rd_reg + {32'd0, len_reg};
            end
        end
        hist_we   = clearing || (state_reg == S_HIST);
        hist_wblk = clearing ? '0 : gblk_rd_reg + 64'd1;
        hist_wins = clearing ? '0 : gins_rd_reg + {32'd0, len_reg};
    end

    logic [HIST_W-1:0] hist_addr;
    assign hist_addr = clearing ? HIST_W'(clr_reg) : bk_reg;

    always_ff @(posedge clk)
    begin
        if (head_we) begin
            head_pc_mem[head_addr]  <= head_wpc;
            head_blk_mem[head_addr] <= head_wblk;
            head_ins_mem[head_addr] <= head_wins;
        end
        hpc_rd_reg  <= head_pc_mem[head_addr];
        hblk_rd_reg <= head_blk_mem[head_addr];
        hins_rd_reg <= head_ins_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we && (!clearing || clr_reg <= SLOT_W'(TOP_BUCKET))) begin
            hist_blk_mem[hist_addr] <= hist_wblk;
            hist_ins_mem[hist_addr] <= hist_wins;
        end
        gblk_rd_reg <= hist_blk_mem[hist_addr];
        gins_rd_reg <= hist_ins_mem[hist_addr];
    end

    logic [31:0] h0;
    assign h0 = start_reg ^ (start_reg >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            sum_blocks_reg <= '0;
            sum_instrs_reg <= '0;
            sum_sq_reg     <= '0;
            for (int i = 0; i < NUM_CORES; i++) begin
                run_expected_reg[i] <= '0;
                run_start_reg[i]    <= '0;
                run_length_reg[i]   <= '0;
            end
        end else begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                    if (clr_reg == SLOT_W'(HEAD_SLOTS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_valid && in_ready && 32'(core) < 32'(NUM_CORES)) begin
                        start_reg    <= run_start_reg[in_core];
                        len_reg      <= cur_len;
                        bk_reg       <= (cur_len < 32'(TOP_BUCKET)) ?
                                        HIST_W'(cur_len) : HIST_W'(TOP_BUCKET);
                        if (func == FUNC_CLOSE || pc != run_expected_reg[in_core]) begin
                            if (cur_len != 32'd0)
                                state_reg <= S_HASH1;
                            if (func == FUNC_CLOSE)
                                run_length_reg[in_core] <= '0;
                            else begin
                                run_start_reg[in_core]  <= pc;
                                run_length_reg[in_core] <= 32'd1;
                                run_expected_reg[in_core] <= next_pc;
                            end
                        end else begin
                            if (cur_len != 32'hFFFF_FFFF)
                                run_length_reg[in_core] <= cur_len + 32'd1;
                            run_expected_reg[in_core] <= next_pc;
                        end
                    end
                end
                S_HASH1: begin
                    hash_reg  <= h0 * HASH_MUL;
                    sq_reg    <= {32'd0, len_reg} * {32'd0, len_reg};
                    probe_reg <= '0;
                    state_reg <= S_HASH2;
                end
                S_HASH2: begin
                    hash_reg  <= hash_reg ^ (hash_reg >> 13);
                    state_reg <= S_HREAD;
                end
                S_HREAD: state_reg <= S_HWAIT;  // address presented, data next
                S_HWAIT: state_reg <= S_HCHK;
                S_HCHK: begin
                    if (probe_reg == PROBE_W'(MAX_PROBES)) begin
                        head_outcome <= OUTCOME_DROPPED;
                        head_slot    <= '0;
                        head_blocks  <= '0;
                        head_instrs  <= '0;
                        state_reg    <= S_HIST;
                    end else if (head_we) begin
                        head_outcome <= (hblk_rd_reg == '0) ? OUTCOME_NEW : OUTCOME_MATCH;
                        head_slot    <= 12'(head_addr);
                        head_blocks  <= head_wblk;
                        head_instrs  <= head_wins;
                        state_reg    <= S_HIST;
                    end else begin
                        probe_reg <= probe_reg + PROBE_W'(1);
                        state_reg <= S_HREAD;
                    end
                end
                S_HIST: begin
                    // Histogram read data has been stable since entry to the close.
                    bucket_blocks <= hist_wblk;
                    bucket_instrs <= hist_wins;
                    state_reg     <= S_HISTW;
                end
                S_HISTW: begin
                    sum_blocks_reg <= sum_blocks_reg + 64'd1;
                    sum_instrs_reg <= sum_instrs_reg + {32'd0, len_reg};
                    sum_sq_reg     <= sum_sq_reg + sq_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    block_start       <= start_reg;
                    block_length      <= len_reg;
                    bucket            <= 7'(bk_reg);
                    total_blocks      <= sum_blocks_reg;
                    total_instrs      <= sum_instrs_reg;
                    total_len_squared <= sum_sq_reg;
                    out_valid         <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
